// ===== rtl/core/tlu_pkg.sv =====
// Shared widths, constants and status types for the tridiagonal LU factor unit.
package tlu_pkg;

   // Field widths fixed by the row format
   localparam int DATA_W = 32;
   localparam int BIAS_W = 16;

   // Pivot bias after reset, about 0.001 in Q16.16
   localparam logic [BIAS_W-1:0] BIAS_RESET = 16'd66;

   // Saturation limits of a 32-bit signed result
   localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

   // Status of the pivot unit
   typedef struct packed {
      logic done;
      logic saturated;
   } pivot_status_type;

   // Status of the iterative divider
   typedef struct packed {
      logic done;
      logic saturated;
   } div_status_type;

endpackage

// ===== rtl/core/tlu_pivot.sv =====
// Pivot unit: l = diag - floor((c * u_prev) / 2^FRAC_BITS), saturated to 32 bits.
module tlu_pivot #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tlu_pkg::DATA_W-1:0] lower,
   input  logic signed [tlu_pkg::DATA_W-1:0] prev_upper,
   input  logic signed [tlu_pkg::DATA_W-1:0] diag,
   output logic signed [tlu_pkg::DATA_W-1:0] pivot,
   output tlu_pkg::pivot_status_type         status
);
   import tlu_pkg::*;

   localparam int PROD_W = 2 * DATA_W;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] diag_ff;
   logic                     stage1_ff;
   logic signed [DATA_W-1:0] pivot_ff, pivot_in;
   logic                     sat_ff, sat_in;
   logic                     done_ff;

   logic signed [PROD_W-1:0] shifted;
   logic        [PROD_W:0]   diff;
   logic                     ovf_pos, ovf_neg;

   // Stage 1: exact product
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= lower * prev_upper;
         diag_ff <= diag;
      end
   end

   // Stage 2: floor shift, subtract, saturate
   always_comb begin
      shifted = prod_ff >>> FRAC_BITS;
      diff    = {{(PROD_W - DATA_W + 1){diag_ff[DATA_W-1]}}, diag_ff}
                - {shifted[PROD_W-1], shifted};
      ovf_pos = !diff[PROD_W] && (diff[PROD_W-1:DATA_W-1] != '0);
      ovf_neg = diff[PROD_W] && (diff[PROD_W-1:DATA_W-1] != '1);
      sat_in  = ovf_pos || ovf_neg;
      if (ovf_pos) begin
         pivot_in = S32_MAX;
      end else if (ovf_neg) begin
         pivot_in = S32_MIN;
      end else begin
         pivot_in = diff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage1_ff) begin
         pivot_ff <= pivot_in;
         sat_ff   <= sat_in;
      end
   end

   // Stage tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= start;
         done_ff   <= stage1_ff;
      end
   end

   assign pivot            = pivot_ff;
   assign status.done      = done_ff;
   assign status.saturated = sat_ff;

endmodule

// ===== rtl/core/tlu_divider.sv =====
// Iterative restoring divider: u = (super * 2^FRAC_BITS) / (pivot + bias), one bit a cycle.
module tlu_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tlu_pkg::DATA_W-1:0] numer,
   input  logic signed [tlu_pkg::DATA_W-1:0] pivot,
   input  logic        [tlu_pkg::BIAS_W-1:0] bias,
   output logic signed [tlu_pkg::DATA_W-1:0] quotient,
   output tlu_pkg::div_status_type           status
);
   import tlu_pkg::*;

   localparam int NUM_W = DATA_W + FRAC_BITS;  // magnitude of super * 2^F
   localparam int REM_W = DATA_W + 1;          // remainder, below the divisor
   localparam int DVS_W = DATA_W + 2;          // signed divisor pivot + bias
   localparam int CNT_W = $clog2(DATA_W);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_PREP = 2'd1;
   localparam logic [1:0] D_ITER = 2'd2;
   localparam logic [1:0] D_FIN  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic signed [DATA_W-1:0] numer_ff;
   logic signed [DVS_W-1:0]  dvsr_ff;
   logic [REM_W-1:0]         dmag_ff;
   logic [DATA_W-1:0]        nlo_ff;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [DATA_W-1:0]        quo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     neg_ff, ovf_ff, zero_ff;
   logic [DATA_W-1:0]        result_ff, result_in;
   logic                     sat_ff, sat_in;
   logic                     done_ff;

   logic [DATA_W:0]          nabs_wide;
   logic [DATA_W-1:0]        nabs;
   logic [NUM_W-1:0]         nmag;
   logic [DVS_W-1:0]         dabs_wide;
   logic [REM_W-1:0]         ntop;
   logic [REM_W:0]           trial, trial_diff;
   logic                     trial_ge;

   // Operand magnitudes and the early overflow check
   always_comb begin
      nabs_wide = numer_ff[DATA_W-1] ? ((DATA_W+1)'(0) - {numer_ff[DATA_W-1], numer_ff})
                                     : {1'b0, numer_ff};
      nabs      = nabs_wide[DATA_W-1:0];
      nmag      = {nabs, {FRAC_BITS{1'b0}}};
      dabs_wide = dvsr_ff[DVS_W-1] ? (DVS_W'(0) - dvsr_ff) : dvsr_ff;
      ntop      = {{(REM_W - FRAC_BITS){1'b0}}, nmag[NUM_W-1:DATA_W]};
   end

   // One quotient bit per cycle
   always_comb begin
      trial      = {rem_ff, nlo_ff[DATA_W-1]};
      trial_diff = trial - {1'b0, dmag_ff};
      trial_ge   = (trial >= {1'b0, dmag_ff});
      rem_in     = trial_ge ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
   end

   // Sign and saturation of the final quotient
   always_comb begin
      sat_in    = 1'b0;
      result_in = quo_ff;
      if (zero_ff) begin
         sat_in = 1'b1;
         if (numer_ff > 0) begin
            result_in = S32_MAX;
         end else if (numer_ff < 0) begin
            result_in = S32_MIN;
         end else begin
            result_in = '0;
         end
      end else if (ovf_ff) begin
         sat_in    = 1'b1;
         result_in = neg_ff ? S32_MIN : S32_MAX;
      end else if (neg_ff) begin
         if (quo_ff > S32_MIN) begin
            sat_in    = 1'b1;
            result_in = S32_MIN;
         end else begin
            result_in = DATA_W'(0) - quo_ff;
         end
      end else if (quo_ff[DATA_W-1]) begin
         sat_in    = 1'b1;
         result_in = S32_MAX;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         D_IDLE: if (start) state_in = D_PREP;
         D_PREP: state_in = D_ITER;
         D_ITER: if (cnt_ff == '0) state_in = D_FIN;
         D_FIN:  state_in = D_IDLE;
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == D_FIN);
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               numer_ff <= numer;
               dvsr_ff  <= {{(DVS_W - DATA_W){pivot[DATA_W-1]}}, pivot}
                           + {{(DVS_W - BIAS_W){1'b0}}, bias};
            end
         end
         D_PREP: begin
            dmag_ff <= dabs_wide[REM_W-1:0];
            nlo_ff  <= nmag[DATA_W-1:0];
            rem_ff  <= ntop;
            quo_ff  <= '0;
            cnt_ff  <= CNT_W'(DATA_W - 1);
            neg_ff  <= numer_ff[DATA_W-1] ^ dvsr_ff[DVS_W-1];
            ovf_ff  <= (ntop >= dabs_wide[REM_W-1:0]);
            zero_ff <= (dvsr_ff == '0);
         end
         D_ITER: begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DATA_W-2:0], trial_ge};
            nlo_ff <= {nlo_ff[DATA_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
         D_FIN: begin
            result_ff <= result_in;
            sat_ff    <= sat_in;
         end
         default: ;
      endcase
   end

   assign quotient         = result_ff;
   assign status.done      = done_ff;
   assign status.saturated = sat_ff;

endmodule

// ===== rtl/core/tridiagonal_lu_factor_stream_unit.sv =====
// Top level of the streaming tridiagonal LU factor unit: sequencer, state and result register.
// Each accepted row item yields one result item: c = sub (0 on a first row),
// l = diag - c*u_prev, u = super/(l + pivot_bias) (0 on a last row), all signed
// fixed point with FRAC_BITS fraction bits, saturated with a flag. An ordinary row
// passes the two pivot stages, the restoring divider and sequencing before the next
// row can be accepted; a last row skips the divider. req_stall is high while a row
// is in work. The result sits in an output register, so a new row is accepted while
// a result waits.
module tridiagonal_lu_factor_stream_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tlu_pkg::DATA_W-1:0] req_sub_value,
   input  logic signed [tlu_pkg::DATA_W-1:0] req_diag_value,
   input  logic signed [tlu_pkg::DATA_W-1:0] req_super_value,
   input  logic                              req_first_row,
   input  logic                              req_last_row,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [tlu_pkg::DATA_W-1:0] rsp_lower_factor,
   output logic signed [tlu_pkg::DATA_W-1:0] rsp_pivot_factor,
   output logic signed [tlu_pkg::DATA_W-1:0] rsp_upper_factor,
   output logic                              rsp_saturated,
   output logic                              rsp_row_done_last,
   input  logic                              csr_wr_en,
   input  logic        [tlu_pkg::BIAS_W-1:0] csr_wr_data
);
   import tlu_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PIVOT  = 2'd1;
   localparam logic [1:0] S_DIVIDE = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [BIAS_W-1:0]        bias_ff;
   logic signed [DATA_W-1:0] prev_upper_ff;
   logic signed [DATA_W-1:0] lower_ff, lower_in;
   logic signed [DATA_W-1:0] super_ff;
   logic                     last_ff;
   logic signed [DATA_W-1:0] upper_ff, upper_in;
   logic                     sat_ff, sat_in;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_lower_ff, rsp_pivot_ff, rsp_upper_ff;
   logic                     rsp_sat_ff, rsp_last_ff;

   logic                     req_accept;
   logic                     out_load;
   logic                     div_start;
   logic signed [DATA_W-1:0] pivot_value;
   logic signed [DATA_W-1:0] div_quotient;
   pivot_status_type         pivot_status;
   div_status_type           div_status;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign lower_in   = req_first_row ? '0 : req_sub_value;
   assign out_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign div_start  = (state_ff == S_PIVOT) && pivot_status.done && !last_ff;

   tlu_pivot #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pivot (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .lower      (lower_in),
      .prev_upper (prev_upper_ff),
      .diag       (req_diag_value),
      .pivot      (pivot_value),
      .status     (pivot_status)
   );

   tlu_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (super_ff),
      .pivot    (pivot_value),
      .bias     (bias_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Row sequencer
   always_comb begin
      state_in = state_ff;
      upper_in = upper_ff;
      sat_in   = sat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_PIVOT;
         end
         S_PIVOT: begin
            if (pivot_status.done) begin
               if (last_ff) begin
                  upper_in = '0;
                  sat_in   = pivot_status.saturated;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               upper_in = div_quotient;
               sat_in   = pivot_status.saturated || div_status.saturated;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state, register and carried upper factor
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bias_ff       <= BIAS_RESET;
         prev_upper_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) bias_ff <= csr_wr_data;
         if (out_load) begin
            prev_upper_ff <= upper_ff;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Row payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         lower_ff <= lower_in;
         super_ff <= req_super_value;
         last_ff  <= req_last_row;
      end
      upper_ff <= upper_in;
      sat_ff   <= sat_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_lower_ff <= lower_ff;
         rsp_pivot_ff <= pivot_value;
         rsp_upper_ff <= upper_ff;
         rsp_sat_ff   <= sat_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lower_factor  = rsp_lower_ff;
   assign rsp_pivot_factor  = rsp_pivot_ff;
   assign rsp_upper_factor  = rsp_upper_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign rsp_row_done_last = rsp_last_ff;

endmodule

// ===== rtl/core/tlu_checker.sv =====
// Port-level checks for the tridiagonal LU factor unit, bound to the top level.
module tlu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [tlu_pkg::DATA_W-1:0] rsp_upper_factor,
   input logic                              rsp_row_done_last
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // An accepted item keeps the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an item was accepted");

   // A new result only comes out of a row in work
   a_result_from_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no row in work");

   // A last row has no upper factor
   a_last_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_done_last |-> rsp_upper_factor == '0)
      else $error("last row gave a nonzero upper factor");

endmodule

bind tridiagonal_lu_factor_stream_unit tlu_checker u_tlu_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the tridiagonal LU factor unit: directed rows, then random matrices.
module tb;
   import tlu_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int ITEMS_TOTAL = 1400;
   localparam int CALM_ITEMS = 150;
   localparam int TAIL_CYCLES = 60;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES = 5;

   localparam longint S32_HIGH = 64'sd2147483647;
   localparam longint S32_LOW = -64'sd2147483648;
   localparam logic [DATA_W-1:0] ONE_Q = 32'h0001_0000;
   // diagonal that cancels the reset bias, so pivot plus bias is zero
   localparam logic [DATA_W-1:0] CANCEL_BIAS = 32'd0 - 32'(BIAS_RESET);

   typedef struct packed {
      logic signed [DATA_W-1:0] sub;
      logic signed [DATA_W-1:0] diag;
      logic signed [DATA_W-1:0] sup;
      logic                     first_row;
      logic                     last_row;
   } row_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] lower;
      logic signed [DATA_W-1:0] pivot;
      logic signed [DATA_W-1:0] upper;
      logic                     saturated;
      logic                     row_done_last;
   } factors_type;

   typedef struct packed {
      row_type     row;
      logic        typed;
      factors_type want;
   } seed_row_type;

   localparam factors_type NO_WANT = '0;
   localparam int SEED_COUNT = 20;

   // directed rows; typed expectations only where they are obvious
   seed_row_type seed_rows [0:SEED_COUNT-1] = '{
      // first row after reset, ignored sub
      '{'{S32_MAX, ONE_Q, 32'd0, 1'b1, 1'b0}, 1'b1, '{32'd0, ONE_Q, 32'd0, 1'b0, 1'b0}},
      // last row with zero carried upper factor
      '{'{32'h1234_5678, S32_MIN, S32_MAX, 1'b0, 1'b1}, 1'b1,
        '{32'h1234_5678, S32_MIN, 32'd0, 1'b0, 1'b1}},
      // matrix without a first-row flag
      '{'{32'hDEAD_BEEF, 32'h0002_0000, ONE_Q, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{32'h0000_8000, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{32'hFFFF_8000, ONE_Q, S32_MAX, 1'b0, 1'b1}, 1'b0, NO_WANT},
      // one-row matrix
      '{'{S32_MAX, S32_MAX, S32_MIN, 1'b1, 1'b1}, 1'b1, '{32'd0, S32_MAX, 32'd0, 1'b0, 1'b1}},
      // zero divisor, positive, negative and zero numerator
      '{'{ONE_Q, CANCEL_BIAS, ONE_Q, 1'b1, 1'b0}, 1'b1,
        '{32'd0, CANCEL_BIAS, S32_MAX, 1'b1, 1'b0}},
      '{'{ONE_Q, CANCEL_BIAS, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b1,
        '{32'd0, CANCEL_BIAS, S32_MIN, 1'b1, 1'b0}},
      '{'{ONE_Q, CANCEL_BIAS, 32'd0, 1'b1, 1'b0}, 1'b1,
        '{32'd0, CANCEL_BIAS, 32'd0, 1'b1, 1'b0}},
      // quotient saturates high, then pivot saturates low
      '{'{32'd0, 32'd1, S32_MAX, 1'b1, 1'b0}, 1'b1, '{32'd0, 32'd1, S32_MAX, 1'b1, 1'b0}},
      '{'{S32_MAX, S32_MIN, 32'd0, 1'b0, 1'b1}, 1'b1, '{S32_MAX, S32_MIN, 32'd0, 1'b1, 1'b1}},
      // quotient saturates low, then pivot saturates high
      '{'{32'd0, 32'd1, S32_MIN, 1'b1, 1'b0}, 1'b1, '{32'd0, 32'd1, S32_MIN, 1'b1, 1'b0}},
      '{'{S32_MAX, S32_MAX, 32'd0, 1'b0, 1'b1}, 1'b1, '{S32_MAX, S32_MAX, 32'd0, 1'b1, 1'b1}},
      // extremes and rounding of negative products and quotients
      '{'{32'd0, S32_MIN, S32_MAX, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{S32_MIN, S32_MIN, S32_MIN, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b0, NO_WANT},
      '{'{32'd0, 32'd0, 32'h0001_2345, 1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{ONE_Q, 32'hFFFD_0000, ONE_Q, 1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{32'h7FFF_0000, 32'd1, 32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b0, NO_WANT}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_sub_value = '0;
   logic [DATA_W-1:0] req_diag_value = '0;
   logic [DATA_W-1:0] req_super_value = '0;
   logic              req_first_row = 1'b0;
   logic              req_last_row = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_lower_factor;
   logic [DATA_W-1:0] rsp_pivot_factor;
   logic [DATA_W-1:0] rsp_upper_factor;
   logic              rsp_saturated;
   logic              rsp_row_done_last;
   logic              csr_wr_en = 1'b0;
   logic [BIAS_W-1:0] csr_wr_data = '0;

   // predictor state and bookkeeping
   logic [BIAS_W-1:0]        bias_now = BIAS_RESET;
   logic signed [DATA_W-1:0] carried_upper = '0;
   factors_type              expected_factors [$];
   int                       fail_count = 0;
   int                       rows_sent = 0;
   bit                       valid_up = 1'b0;
   bit                       calm_tail = 1'b0;
   int                       send_calm = 0;
   int                       stall_left = 0;
   int                       calm_left = 0;

   tridiagonal_lu_factor_stream_unit #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sub_value     (req_sub_value),
      .req_diag_value    (req_diag_value),
      .req_super_value   (req_super_value),
      .req_first_row     (req_first_row),
      .req_last_row      (req_last_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lower_factor  (rsp_lower_factor),
      .rsp_pivot_factor  (rsp_pivot_factor),
      .rsp_upper_factor  (rsp_upper_factor),
      .rsp_saturated     (rsp_saturated),
      .rsp_row_done_last (rsp_row_done_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // clamp to the 32-bit signed range, raising the flag on overflow
   function automatic longint clamp32(input longint v, inout logic flag);
      if (v > S32_HIGH) begin
         flag = 1'b1;
         return S32_HIGH;
      end
      if (v < S32_LOW) begin
         flag = 1'b1;
         return S32_LOW;
      end
      return v;
   endfunction

   // factor one row and advance the carried upper factor
   function automatic factors_type factor_row(input row_type r);
      factors_type f;
      logic        flag;
      longint      pivot;
      longint      divisor;
      longint      quot;
      flag = 1'b0;
      if (r.first_row) begin
         f.lower = '0;
         pivot = longint'(r.diag);
      end else begin
         f.lower = r.sub;
         pivot = clamp32(longint'(r.diag) -
                         ((longint'(r.sub) * longint'(carried_upper)) >>> FRAC_BITS), flag);
      end
      f.pivot = pivot[DATA_W-1:0];
      if (r.last_row) begin
         f.upper = '0;
      end else begin
         divisor = pivot + longint'({48'd0, bias_now});
         if (divisor == 0) begin
            flag = 1'b1;
            f.upper = (r.sup > 0) ? S32_MAX : ((r.sup < 0) ? S32_MIN : '0);
         end else begin
            quot = clamp32((longint'(r.sup) <<< FRAC_BITS) / divisor, flag);
            f.upper = quot[DATA_W-1:0];
         end
      end
      f.saturated = flag;
      f.row_done_last = r.last_row;
      carried_upper = f.upper;
      return f;
   endfunction

   // mostly small Q16.16 values, with extremes and raw bit patterns mixed in
   function automatic logic signed [DATA_W-1:0] pick_value();
      int v;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 5))
               0: return S32_MAX;
               1: return S32_MIN;
               2: return '0;
               3: return 32'd1;
               4: return 32'hFFFF_FFFF;
               default: return ONE_Q;
            endcase
         end
         default: begin
            v = $urandom_range(0, 1048575);
            return v - 524288;
         end
      endcase
   endfunction

   task automatic drop_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   // offer one row, wait for acceptance, then record its expected factors
   task automatic push_row(input row_type r, input logic typed, input factors_type want);
      factors_type predicted;
      int          gap;
      if (calm_tail || send_calm > 0) begin
         if (send_calm > 0) send_calm--;
      end else if ($urandom_range(0, 19) == 0) begin
         send_calm = $urandom_range(10, 40);
      end else if ($urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 15);
         drop_valid();
         repeat (gap) @(posedge clock);
      end
      req_sub_value <= r.sub;
      req_diag_value <= r.diag;
      req_super_value <= r.sup;
      req_first_row <= r.first_row;
      req_last_row <= r.last_row;
      req_valid <= 1'b1;
      valid_up = 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = factor_row(r);
      expected_factors.push_back(typed ? want : predicted);
      rows_sent++;
   endtask

   // sender holds off until every expected item has come back
   task automatic wait_results();
      drop_valid();
      while (expected_factors.size() != 0) @(posedge clock);
   endtask

   task automatic write_bias(input logic [BIAS_W-1:0] value);
      wait_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bias_now = value;
   endtask

   // one matrix: single row, well-formed, or rows with random flags
   task automatic send_matrix();
      row_type r;
      int      shape;
      int      span;
      longint  aim;
      shape = $urandom_range(0, 9);
      if (shape == 0) span = 1;
      else if ($urandom_range(0, 7) == 0) span = $urandom_range(10, 30);
      else span = $urandom_range(2, 7);
      for (int i = 0; i < span; i++) begin
         r.sub = pick_value();
         r.diag = pick_value();
         r.sup = pick_value();
         if (shape == 1) begin
            r.first_row = 1'($urandom_range(0, 1));
            r.last_row = 1'($urandom_range(0, 1));
         end else begin
            r.first_row = (i == 0);
            r.last_row = (i == span - 1);
         end
         // now and then aim the diagonal so that pivot plus bias is zero
         if ($urandom_range(0, 11) == 0) begin
            aim = -longint'({48'd0, bias_now});
            if (!r.first_row)
               aim += (longint'(r.sub) * longint'(carried_upper)) >>> FRAC_BITS;
            if (aim >= S32_LOW && aim <= S32_HIGH) r.diag = aim[DATA_W-1:0];
         end
         push_row(r, 1'b0, NO_WANT);
         if (rows_sent >= ITEMS_TOTAL - CALM_ITEMS) calm_tail = 1'b1;
      end
   endtask

   // receiver stalls in bursts, with calm stretches between
   always @(posedge clock) begin
      if (reset || calm_tail) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 15))
            0, 1: begin
               stall_left = $urandom_range(1, 15) - 1;
               rsp_stall <= 1'b1;
            end
            2: begin
               calm_left = $urandom_range(30, 200);
               rsp_stall <= 1'b0;
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         fail_count++;
      end
   endtask

   // compare each accepted result item with the oldest expectation
   always @(posedge clock) begin : result_check
      factors_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_factors.size() == 0) begin
            $display("%0t: unexpected result item: lower %h pivot %h upper %h", $time,
                     rsp_lower_factor, rsp_pivot_factor, rsp_upper_factor);
            fail_count++;
         end else begin
            want = expected_factors.pop_front();
            check_field("lower_factor", want.lower, rsp_lower_factor);
            check_field("pivot_factor", want.pivot, rsp_pivot_factor);
            check_field("upper_factor", want.upper, rsp_upper_factor);
            check_field("saturated", 32'(want.saturated), 32'(rsp_saturated));
            check_field("row_done_last", 32'(want.row_done_last), 32'(rsp_row_done_last));
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [BIAS_W-1:0] bias_plan [0:PHASES-1];
      bias_plan[0] = '0;
      bias_plan[1] = '1;
      bias_plan[2] = 16'($urandom_range(2, 65534));
      bias_plan[3] = 16'd1;
      bias_plan[4] = BIAS_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset bias
      for (int k = 0; k < SEED_COUNT; k++)
         push_row(seed_rows[k].row, seed_rows[k].typed, seed_rows[k].want);

      // random matrices under each bias setting
      for (int p = 0; p < PHASES; p++) begin
         write_bias(bias_plan[p]);
         while (rows_sent < SEED_COUNT + (p + 1) * (ITEMS_TOTAL - SEED_COUNT) / PHASES)
            send_matrix();
      end

      wait_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_factors.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
